>>> hdl/gkd_pkg.sv
// Shared types, constants and register indexes for the Gaussian KDE block.
// No dependencies.
package gkd_pkg;

  localparam int DIMS_DEF      = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [30:0] LOG2E_Q30        = 31'd1549082005;
  localparam logic [30:0] LN2_Q30          = 31'd744261118;
  localparam logic [30:0] INV_SQRT_2PI_Q30 = 31'd428361011;
  localparam int          QUEUE_DEPTH      = 4;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd1;
  localparam logic [2:0] REG_IBW_X   = 3'd2;
  localparam logic [2:0] REG_IBW_Z   = 3'd4;
  localparam logic [2:0] REG_IRAD_X  = 3'd5;
  localparam logic [2:0] REG_IRAD_Z  = 3'd7;

  // back end sequencer
  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_A, ST_A2, ST_U, ST_V, ST_T, ST_X, ST_SER, ST_SDIV, ST_W, ST_C, ST_P,
    ST_ACC
  } be_state_t;

  // one queued word: offsets and the two flags
  typedef struct packed {
    logic [2:0][32:0] diff;
    logic             has_neighbor;
    logic             last_of_sample;
  } gkd_word_t;

endpackage

>>> hdl/gkd_front.sv
// Front end: accepts input words, forms the per-axis offsets and drops
// words that neither contribute nor end a sample. Uses gkd_pkg.
module gkd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_center_x,
  input  logic [31:0]       in_center_y,
  input  logic [31:0]       in_center_z,
  input  logic [31:0]       in_neighbor_x,
  input  logic [31:0]       in_neighbor_y,
  input  logic [31:0]       in_neighbor_z,
  input  logic              in_has_neighbor,
  input  logic              in_last_of_sample,
  output logic              q_push,
  output gkd_pkg::gkd_word_t q_word,
  input  logic              q_full
);
  import gkd_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_has_neighbor || in_last_of_sample);

  always_comb begin
    q_word.diff[0] = {in_neighbor_x[31], in_neighbor_x} - {in_center_x[31], in_center_x};
    q_word.diff[1] = {in_neighbor_y[31], in_neighbor_y} - {in_center_y[31], in_center_y};
    q_word.diff[2] = {in_neighbor_z[31], in_neighbor_z} - {in_center_z[31], in_center_z};
    q_word.has_neighbor   = in_has_neighbor;
    q_word.last_of_sample = in_last_of_sample;
  end

  logic unused_ok;
  assign unused_ok = clk ^ rst_n;

endmodule

>>> hdl/gkd_queue.sv
// Short word queue between the front and back ends. Uses gkd_pkg.
module gkd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gkd_pkg::gkd_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output gkd_pkg::gkd_word_t head
);
  import gkd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  gkd_word_t       mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full      = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

>>> hdl/gkd_back.sv
// Back end: a sequencer that evaluates the per-axis Gaussian factors with a
// shared multiplier step, multiplies them together and accumulates. Uses gkd_pkg.
module gkd_back #(
  parameter int DIMS      = gkd_pkg::DIMS_DEF,
  parameter int FRAC_BITS = gkd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  gkd_pkg::gkd_word_t q_head,
  output logic               q_pop,
  input  logic               cfg_mode,
  input  logic [31:0]        sqrt_bw,
  input  logic [2:0][31:0]   ibw,
  input  logic [2:0][31:0]   irad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_density,
  output logic               out_saturated
);
  import gkd_pkg::*;

  localparam logic [63:0] U_CAP   = 64'(16) << FRAC_BITS;
  localparam logic [63:0] VAL_CAP = 64'h1_0000_0000;

  be_state_t    st_r, st_nxt;
  logic [1:0]   ax_r, ax_nxt;
  logic [3:0]   n_r, n_nxt;
  logic [63:0]  a_r, a_nxt;      // working value
  logic [63:0]  x_r, x_nxt;      // series argument
  logic [30:0]  r_r, r_nxt;      // series value
  logic [5:0]   k_r, k_nxt;
  logic [32:0]  p_r, p_nxt;      // product over axes
  logic [32:0]  sum_r, sum_nxt;
  logic [31:0]  bw;
  logic         outv_r, outv_nxt;
  logic [31:0]  outd_r, outd_nxt;
  logic         outs_r, outs_nxt;
  logic [32:0]  d;
  logic [127:0] prod;
  logic [63:0]  qv, mag;
  logic [32:0]  cap_p;
  logic [33:0]  acc;

  // ceil(2^34 / n): exact truncating quotient for dividends below 2^30
  function automatic logic [34:0] recip_q34(logic [3:0] n);
    unique case (n)
      4'd2:    return 35'd8589934592;
      4'd3:    return 35'd5726623062;
      4'd4:    return 35'd4294967296;
      4'd5:    return 35'd3435973837;
      4'd6:    return 35'd2863311531;
      4'd7:    return 35'd2454267027;
      4'd8:    return 35'd2147483648;
      4'd9:    return 35'd1908874354;
      4'd10:   return 35'd1717986919;
      4'd11:   return 35'd1561806290;
      4'd12:   return 35'd1431655766;
      default: return 35'd17179869184;
    endcase
  endfunction

  assign bw  = cfg_mode ? sqrt_bw : ibw[ax_r];
  assign d   = q_head.diff[ax_r];
  assign mag = d[32] ? 64'(-d) : 64'(d);
  assign out_valid     = outv_r;
  assign out_density   = outd_r;
  assign out_saturated = outs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; sum_r <= '0; outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sum_r <= sum_nxt; outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; n_r <= n_nxt; a_r <= a_nxt; x_r <= x_nxt; r_r <= r_nxt;
    k_r <= k_nxt; p_r <= p_nxt; outd_r <= outd_nxt; outs_r <= outs_nxt;
  end

  always_comb begin
    st_nxt = st_r; ax_nxt = ax_r; n_nxt = n_r; a_nxt = a_r; x_nxt = x_r;
    r_nxt = r_r; k_nxt = k_r; p_nxt = p_r; sum_nxt = sum_r;
    outv_nxt = outv_r && out_stall; outd_nxt = outd_r; outs_nxt = outs_r;
    q_pop = 1'b0; prod = '0; qv = '0; cap_p = '0; acc = '0;
    unique case (st_r)
      ST_IDLE: begin
        ax_nxt = '0;
        p_nxt  = '0;
        if (q_not_empty) st_nxt = q_head.has_neighbor ? ST_MAG : ST_ACC;
      end
      ST_MAG: begin
        prod  = 128'(mag[31:0]) * 128'(bw);
        a_nxt = prod[FRAC_BITS +: 64];
        st_nxt = ST_A;
      end
      ST_A: begin
        // low part of a times the inverse radius; the high part follows
        prod  = 128'(a_r[23:0]) * 128'(irad[ax_r]);
        x_nxt = prod[63:0];
        st_nxt = ST_A2;
      end
      ST_A2: begin
        prod  = (128'(a_r[55:24]) * 128'(irad[ax_r])) << 24;
        prod  = (prod + 128'(x_r)) >> FRAC_BITS;
        a_nxt = (prod > 128'(U_CAP)) ? U_CAP : prod[63:0];
        st_nxt = ST_U;
      end
      ST_U: begin
        prod  = 128'(a_r[28:0]) * 128'(a_r[28:0]);
        a_nxt = 64'(prod >> (FRAC_BITS + 1));
        st_nxt = ST_V;
      end
      ST_V: begin
        prod  = 128'(a_r[31:0]) * 128'(LOG2E_Q30);
        a_nxt = prod[63:0];
        st_nxt = ST_T;
      end
      ST_T: begin
        qv    = a_r >> (FRAC_BITS + 30);
        k_nxt = (qv >= 64'd31) ? 6'd31 : qv[5:0];
        qv    = (a_r >> FRAC_BITS) & 64'h3FFF_FFFF;
        prod  = 128'(qv) * 128'(LN2_Q30);
        x_nxt = 64'(prod >> 30);
        r_nxt = 31'h4000_0000;
        n_nxt = 4'd12;
        st_nxt = ST_SER;
      end
      ST_SER: begin
        // one Horner term per pass: multiply here, divide by n next
        prod  = 128'(x_r[29:0]) * 128'(r_r);
        a_nxt = 64'(prod >> 30);
        st_nxt = ST_SDIV;
      end
      ST_SDIV: begin
        prod  = 128'(a_r[29:0]) * 128'(recip_q34(n_r));
        qv    = 64'(prod >> 34);
        r_nxt = 31'(64'h4000_0000 - qv);
        n_nxt = n_r - 1'b1;
        st_nxt = (n_r == 4'd1) ? ST_X : ST_SER;
      end
      ST_X: begin
        a_nxt  = (k_r == 6'd31) ? 64'd0 : 64'(r_r >> k_r);
        st_nxt = ST_W;
      end
      ST_W: begin
        prod  = 128'(a_r[30:0]) * 128'(INV_SQRT_2PI_Q30);
        a_nxt = 64'(prod >> 30);
        st_nxt = ST_C;
      end
      ST_C: begin
        prod  = 128'(bw) * 128'(a_r[30:0]);
        a_nxt = 64'(prod >> 30);
        st_nxt = ST_P;
      end
      ST_P: begin
        if (ax_r == 2'd0) qv = a_r;
        else begin
          prod = 128'(p_r) * 128'(a_r[31:0]);
          qv   = 64'(prod >> FRAC_BITS);
        end
        p_nxt = (qv > VAL_CAP) ? 33'(VAL_CAP) : qv[32:0];
        if (32'(ax_r) == 32'(DIMS - 1)) st_nxt = ST_ACC;
        else begin
          ax_nxt = ax_r + 1'b1;
          st_nxt = ST_MAG;
        end
      end
      ST_ACC: begin
        cap_p = q_head.has_neighbor ? p_r : 33'd0;
        acc   = 34'(sum_r) + 34'(cap_p);
        if (q_head.last_of_sample) begin
          if (!outv_r || !out_stall) begin
            outv_nxt = 1'b1;
            outs_nxt = (acc > 34'hFFFF_FFFF);
            outd_nxt = outs_nxt ? 32'hFFFF_FFFF : acc[31:0];
            sum_nxt  = '0;
            q_pop    = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end else begin
          sum_nxt = (acc > 34'(VAL_CAP)) ? 33'(VAL_CAP) : acc[32:0];
          q_pop   = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> st_r == ST_ACC)
    else $error("pop outside accumulate");
  assert property (@(posedge clk) disable iff (!rst_n) sum_r <= 33'(VAL_CAP))
    else $error("sum above cap");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last_of_sample) |=> out_valid && sum_r == '0)
    else $error("result not raised");

endmodule

>>> hdl/gkd_sqrt.sv
// Bit-serial square root of the count register for the mode 1 bandwidth,
// rerun on every write to the count register. Uses gkd_pkg.
module gkd_sqrt #(
  parameter int FRAC_BITS = gkd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] count,
  output logic [31:0] root,
  output logic        busy
);
  import gkd_pkg::*;

  logic [31:0] r_r, r_nxt, t;
  logic [5:0]  b_r;
  logic        busy_r;
  logic [63:0] target;
  logic        big;

  assign big    = (64'(count) >> (64 - 2*FRAC_BITS)) != '0;
  assign target = big ? 64'd0 : (64'(count) << (2*FRAC_BITS));
  assign t      = r_r | (32'd1 << b_r[4:0]);
  assign r_nxt  = (big || 64'(t) * 64'(t) <= target) ? t : r_r;
  assign root   = r_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1; b_r <= 6'd31; r_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1; b_r <= 6'd31; r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= b_r - 1'b1;
      if (b_r == 6'd0) busy_r <= 1'b0;
    end
  end

endmodule

>>> hdl/gaussian_kde_neighbor_density.sv
// Top level of the Gaussian kernel density block: configuration registers,
// front end, word queue, back end and square-root unit. Uses gkd_pkg.
//
// In the back end each axis of a word with a neighbour runs through the
// shared multiply step (split in two, ST_A then ST_A2, for the inverse
// radius) and the twelve-term exponential series (each term a multiply,
// then a divide). A word that only ends an empty sample goes straight from
// idle to accumulate. Words without a neighbour that do not end a sample
// are dropped in the front end. A four-word queue lets the input side run
// ahead; a result held by the receiver stops the back end at the next
// sample end. After reset or a count write no words are taken, in either
// mode, until the square root has finished.
module gaussian_kde_neighbor_density #(
  parameter int DIMS      = gkd_pkg::DIMS_DEF,
  parameter int FRAC_BITS = gkd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_center_x,
  input  logic [31:0] in_center_y,
  input  logic [31:0] in_center_z,
  input  logic [31:0] in_neighbor_x,
  input  logic [31:0] in_neighbor_y,
  input  logic [31:0] in_neighbor_z,
  input  logic        in_has_neighbor,
  input  logic        in_last_of_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_density,
  output logic        out_saturated
);
  import gkd_pkg::*;

  logic             mode_r;
  logic [23:0]      count_r;
  logic [2:0][31:0] ibw_r, irad_r;
  logic [31:0]      root;
  logic             sq_busy, sq_start, q_push, q_full, q_pop, q_ne, fe_stall;
  gkd_word_t        q_in, q_head;

  assign sq_start = cfg_we && cfg_index == REG_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; count_r <= 24'd1;
      ibw_r  <= {3{32'(1) << FRAC_BITS}};
      irad_r <= {3{32'(1) << FRAC_BITS}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r <= cfg_data[0];
        REG_COUNT: count_r <= cfg_data[23:0];
        default: begin
          if (cfg_index >= REG_IBW_X && cfg_index <= REG_IBW_Z)
            ibw_r[2'(cfg_index - REG_IBW_X)] <= cfg_data;
          else if (cfg_index >= REG_IRAD_X && cfg_index <= REG_IRAD_Z)
            irad_r[2'(cfg_index - REG_IRAD_X)] <= cfg_data;
        end
      endcase
    end
  end

  gkd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst_n, .start(sq_start), .count(count_r), .root, .busy(sq_busy)
  );

  gkd_front u_front (
    .clk, .rst_n, .in_valid(in_valid && !sq_busy), .in_stall(fe_stall),
    .in_center_x, .in_center_y, .in_center_z,
    .in_neighbor_x, .in_neighbor_y, .in_neighbor_z,
    .in_has_neighbor, .in_last_of_sample,
    .q_push, .q_word(q_in), .q_full(q_full || sq_busy)
  );
  assign in_stall = fe_stall;

  gkd_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_word(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head(q_head)
  );

  gkd_back #(.DIMS(DIMS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_not_empty(q_ne), .q_head, .q_pop,
    .cfg_mode(mode_r), .sqrt_bw(root), .ibw(ibw_r), .irad(irad_r),
    .out_valid, .out_stall, .out_density, .out_saturated
  );

endmodule
